>>> sv/vkt_pkg.sv
// Shared types and constants for the versioned key table upsert unit.
// Holds field widths, record and result structs, and the status, function
// and state codes. No dependencies.
package vkt_pkg;

  localparam int VKT_CAPACITY = 16;

  localparam int KEY_W  = 64;
  localparam int PROD_W = 64;
  localparam int CUR_W  = 24;
  localparam int VER_W  = 32;
  localparam int REV_W  = 32;
  localparam int CHAR_W = 8;

  localparam logic [REV_W-1:0] REV_RESET = REV_W'(1);

  typedef enum logic {
    FN_FIND   = 1'b0,
    FN_UPSERT = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_BADARG = 2'd1,
    STS_STALE  = 2'd2,
    STS_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } ctrl_state_t;

  // One stored table entry
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PROD_W-1:0] product;
    logic [CUR_W-1:0]  currency;
    logic [VER_W-1:0]  version;
  } rec_t;

  // One result beat
  typedef struct packed {
    status_t           status;
    logic              found;
    logic [PROD_W-1:0] product;
    logic [CUR_W-1:0]  currency;
    logic [VER_W-1:0]  version;
    logic [REV_W-1:0]  revision;
  } res_t;

  // Record store strobes from the sequencer
  typedef struct packed {
    logic wr;
    logic rd;
  } mem_ctl_t;

endpackage

>>> sv/vkt_if.sv
// Valid/ready channel interfaces for the request and response beats.
// Depends on vkt_pkg for field widths.
interface vkt_req_if
  import vkt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              func;
  logic [KEY_W-1:0]  key;
  logic [PROD_W-1:0] product_id;
  logic [CUR_W-1:0]  currency;
  logic [VER_W-1:0]  version;

  modport source (output valid, func, key, product_id, currency, version, input ready);
  modport sink (input valid, func, key, product_id, currency, version, output ready);
endinterface

interface vkt_rsp_if
  import vkt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic              found;
  logic [PROD_W-1:0] out_product;
  logic [CUR_W-1:0]  out_currency;
  logic [VER_W-1:0]  out_version;
  logic [REV_W-1:0]  revision_now;

  modport source (output valid, status, found, out_product, out_currency, out_version,
                  revision_now, input ready);
  modport sink (input valid, status, found, out_product, out_currency, out_version,
                revision_now, output ready);
endinterface

>>> sv/vkt_store.sv
// Record store: one write port and one registered read port over the
// table entries. Depends on vkt_pkg for the record type.
module vkt_store
  import vkt_pkg::*;
#(
  parameter int CAPACITY = VKT_CAPACITY,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  mem_ctl_t      mem_ctl,
  input  logic [AW-1:0] waddr,
  input  rec_t          wdata,
  input  logic [AW-1:0] raddr,
  output rec_t          rdata
);

  rec_t mem [CAPACITY];

  // Write one entry
  always_ff @(posedge clk) begin
    if (mem_ctl.wr) begin
      mem[waddr] <= wdata;
    end
  end

  // Read one entry, registered
  always_ff @(posedge clk) begin
    if (mem_ctl.rd) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/vkt_ctrl.sv
// Sequencer for find and upsert: scans filled entries one per cycle through
// the shared key comparator, decides, writes back and drives the result
// register. Depends on vkt_pkg and the channel interfaces.
module vkt_ctrl
  import vkt_pkg::*;
#(
  parameter int CAPACITY = VKT_CAPACITY,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic           clk,
  input  logic           rst,
  vkt_req_if.sink        req,
  vkt_rsp_if.source      rsp,
  output mem_ctl_t       mem_ctl,
  output logic [AW-1:0]  waddr,
  output rec_t           wdata,
  output logic [AW-1:0]  raddr,
  input  rec_t           rdata
);

  ctrl_state_t       state, state_next;
  func_t             func_r;
  logic [KEY_W-1:0]  key_r;
  logic [PROD_W-1:0] prod_r;
  logic [CUR_W-1:0]  cur_r;
  logic [VER_W-1:0]  ver_r;
  logic [CW-1:0]     fill_count, fill_count_next;
  logic [REV_W-1:0]  revision, revision_next;
  logic [CW-1:0]     rd_idx;
  logic              cmp_vld;
  logic [AW-1:0]     cmp_idx;
  res_t              res, res_next;
  res_t              obuf;
  logic              obuf_valid;

  logic              accept;
  logic              bad_arg;
  logic              issue;
  logic              hit;
  logic              scan_done;
  logic              out_free;
  logic              load_out;

  assign accept   = req.valid && req.ready;
  assign bad_arg  = (req.key[KEY_W-1 -: CHAR_W] == '0) ||
                    (req.product_id[PROD_W-1 -: CHAR_W] == '0) ||
                    (req.currency[CUR_W-1 -: CHAR_W] == '0);
  assign issue    = (rd_idx < fill_count);
  assign hit      = cmp_vld && (rdata.key == key_r);
  assign scan_done = hit || !issue;
  assign out_free = !obuf_valid || rsp.ready;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if ((func_t'(req.func) == FN_UPSERT) && bad_arg) begin
            state_next = S_FINISH;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake and result load strobes
  always_comb begin
    req.ready = 1'b0;
    load_out = 1'b0;
    case (state)
      S_IDLE:   req.ready = 1'b1;
      S_FINISH: load_out = out_free;
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  assign raddr = rd_idx[AW-1:0];

  // Decide the item: store strobes, result, write-back, fill and revision updates
  always_comb begin
    res_next        = res;
    fill_count_next = fill_count;
    revision_next   = revision;
    mem_ctl.rd      = (state == S_SCAN) && issue;
    mem_ctl.wr      = 1'b0;
    waddr           = cmp_idx;
    wdata           = '{key: key_r, product: prod_r, currency: cur_r, version: ver_r};
    if (state == S_IDLE) begin
      res_next = '{status: STS_BADARG, found: 1'b0, product: '0, currency: '0,
                   version: '0, revision: revision};
    end else if ((state == S_SCAN) && scan_done) begin
      res_next = '{status: STS_OK, found: 1'b0, product: '0, currency: '0,
                   version: '0, revision: revision};
      if (func_r == FN_FIND) begin
        if (hit) begin
          res_next.found    = 1'b1;
          res_next.product  = rdata.product;
          res_next.currency = rdata.currency;
          res_next.version  = rdata.version;
        end
      end else if (hit) begin
        if (ver_r < rdata.version) begin
          res_next.status = STS_STALE;
        end else begin
          mem_ctl.wr        = 1'b1;
          revision_next     = revision + REV_W'(1);
          res_next.revision = revision_next;
        end
      end else if (fill_count >= CW'(CAPACITY)) begin
        res_next.status = STS_FULL;
      end else begin
        mem_ctl.wr        = 1'b1;
        waddr             = fill_count[AW-1:0];
        fill_count_next   = fill_count + CW'(1);
        revision_next     = revision + REV_W'(1);
        res_next.revision = revision_next;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      revision   <= REV_RESET;
      rd_idx     <= '0;
      cmp_vld    <= 1'b0;
      obuf_valid <= 1'b0;
    end else begin
      state      <= state_next;
      fill_count <= fill_count_next;
      revision   <= revision_next;
      cmp_vld    <= mem_ctl.rd;
      if (state == S_IDLE) begin
        rd_idx <= '0;
      end else if (mem_ctl.rd) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (load_out) begin
        obuf_valid <= 1'b1;
      end else if (rsp.ready) begin
        obuf_valid <= 1'b0;
      end
    end
  end

  // Hold the item payload, the compare index and the result
  always_ff @(posedge clk) begin
    cmp_idx <= rd_idx[AW-1:0];
    res     <= res_next;
    if (accept) begin
      func_r <= func_t'(req.func);
      key_r  <= req.key;
      prod_r <= req.product_id;
      cur_r  <= req.currency;
      ver_r  <= req.version;
    end
    if (load_out) begin
      obuf <= res;
    end
  end

  // Drive the response beat
  assign rsp.valid        = obuf_valid;
  assign rsp.status       = obuf.status;
  assign rsp.found        = obuf.found;
  assign rsp.out_product  = obuf.product;
  assign rsp.out_currency = obuf.currency;
  assign rsp.out_version  = obuf.version;
  assign rsp.revision_now = obuf.revision;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CW'(CAPACITY))
    else $error("fill count beyond capacity");

  a_rev_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (revision == $past(revision)) ||
             (revision == $past(revision) + REV_W'(1)))
    else $error("revision moved by more than one");

  a_wr_in_scan: assert property (@(posedge clk) disable iff (rst)
    mem_ctl.wr |-> (state == S_SCAN) && (func_r == FN_UPSERT))
    else $error("store write outside an upsert scan");

  a_fill_on_append: assert property (@(posedge clk) disable iff (rst)
    (fill_count_next != fill_count) |-> mem_ctl.wr && !hit)
    else $error("fill count changed without an append");

endmodule

>>> sv/versioned_key_table_upsert_unit.sv
// Versioned key table: find and upsert over up to CAPACITY records, one
// request beat in and one response beat out per item. The table is scanned
// linearly through a single registered read port and one key comparator, one
// entry per cycle, until a key match or the end of the filled entries; a new
// request is taken only once the last result is loaded, and an upsert with an
// empty key, product or currency skips the scan. The finished response sits in
// an output register while the next request is taken. No clearing pass is
// needed after reset: only entries below the fill count are ever read.
module versioned_key_table_upsert_unit
  import vkt_pkg::*;
#(
  parameter int CAPACITY = VKT_CAPACITY
) (
  input  logic      clk,
  input  logic      rst,
  vkt_req_if.sink   req,
  vkt_rsp_if.source rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  mem_ctl_t      mem_ctl;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  rec_t          wdata;
  rec_t          rdata;

  // Sequencer and comparator
  vkt_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .mem_ctl (mem_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  // Entry storage
  vkt_store #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_store (
    .clk     (clk),
    .mem_ctl (mem_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata   (rdata)
  );

endmodule
